>>> rtl/lgst_pkg.sv
// Shared constants, types and fixed-point helpers for the log Stirling table.
// No dependencies; used by every module under rtl/.
`default_nettype none
package lgst_pkg;

  // value format: signed Q15.16 in 32 bits, ln(0) as the most negative code
  localparam int FRAC_BITS = 16;
  localparam int Q_SHIFT   = 30 - FRAC_BITS;
  localparam int LN_W      = 40;                  // signed Q30 result of the ln unit
  localparam int TERM_W    = 31;                  // Taylor term, up to 1.0 in Q30
  localparam int DEN_W     = 4;                   // Taylor divisor, 1..12
  localparam int TAYLOR_TERMS = 12;
  localparam int D_W       = FRAC_BITS + 5;       // clipped difference, up to 16.0

  localparam int DEF_MAX_ROWS = 256;
  localparam int DEF_MAX_COLS = 64;

  localparam logic [30:0] ONE_Q30  = 31'h4000_0000;
  localparam logic [29:0] HALF_Q30 = 30'h2000_0000;
  localparam logic [29:0] LN2_Q30  = 30'd744261118;
  localparam logic [29:0] EM1_Q30  = 30'd395007542;
  localparam logic [D_W-1:0] CLIP_D = D_W'(16) << FRAC_BITS;

  localparam logic signed [31:0] NEG_CODE = 32'sh8000_0000;
  localparam logic signed [40:0] CODE_MAX = 41'sd2147483647;
  localparam logic signed [40:0] CODE_MIN = -41'sd2147483647;

  localparam logic OP_BUILD = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [1:0] REG_DISCOUNT = 2'd0;
  localparam logic [1:0] REG_ROWS     = 2'd1;
  localparam logic [1:0] REG_COLS     = 2'd2;

  // Q30 to FRAC_BITS, rounding half away from zero
  function automatic logic signed [LN_W-1:0] q30_to_frac(input logic signed [LN_W-1:0] v);
    logic signed [LN_W-1:0] half;
    half = LN_W'(1) <<< (Q_SHIFT - 1);
    if (v >= 0) return (v + half) >>> Q_SHIFT;
    return -((-v + half) >>> Q_SHIFT);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [40:0] v);
    if (v > CODE_MAX) return 32'sh7fff_ffff;
    if (v < CODE_MIN) return 32'sh8000_0001;
    return v[31:0];
  endfunction

endpackage
`default_nettype wire

>>> rtl/lgst_div.sv
// Divide-by-small-constant unit for the Taylor terms: reciprocal multiply, registered quotient.
// Depends on lgst_pkg for the operand widths; numerators stay below 2^30.
`default_nettype none
module lgst_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [lgst_pkg::TERM_W-1:0]   num,
  input  wire logic [lgst_pkg::DEN_W-1:0]    den,
  output logic                               done,
  output logic [lgst_pkg::TERM_W-1:0]        quot
);
  localparam int TW = lgst_pkg::TERM_W;
  localparam int RS = 33;
  localparam int PW = TW + 34;

  logic [33:0]   recip;
  logic [PW-1:0] prod;

  // ceil(2^33 / den); the error term stays below 2^33 / num, so the floor is exact
  always_comb begin
    case (den)
      4'd1:    recip = 34'd8589934592;
      4'd2:    recip = 34'd4294967296;
      4'd3:    recip = 34'd2863311531;
      4'd4:    recip = 34'd2147483648;
      4'd5:    recip = 34'd1717986919;
      4'd6:    recip = 34'd1431655766;
      4'd7:    recip = 34'd1227133514;
      4'd8:    recip = 34'd1073741824;
      4'd9:    recip = 34'd954437177;
      4'd10:   recip = 34'd858993460;
      4'd11:   recip = 34'd780903145;
      4'd12:   recip = 34'd715827883;
      default: recip = '0;
    endcase
    prod = PW'(num) * PW'(recip);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= start;
      if (start) quot <= TW'(prod >> RS);
    end
  end
endmodule
`default_nettype wire

>>> rtl/lgst_ln.sv
// Natural log unit: normalize, 30 squaring rounds for the log2 fraction, scale by ln2.
// Depends on lgst_pkg; result is signed Q30.
`default_nettype none
module lgst_ln (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  input  wire logic [31:0]                        x,
  input  wire logic [4:0]                         xfrac,
  output logic                                    done,
  output logic signed [lgst_pkg::LN_W-1:0]        result
);
  typedef enum logic [2:0] {L_IDLE, L_NORM, L_SQ, L_FRAC, L_SUM} ln_state_t;

  ln_state_t   state;
  logic [31:0] xs;
  logic [5:0]  p;
  logic [4:0]  xf;
  logic [30:0] m;
  logic [29:0] frac;
  logic [29:0] fr;
  logic [4:0]  cnt;

  logic [61:0] sq;
  logic [31:0] mm;
  logic [59:0] fp;
  logic signed [6:0]  pe;
  logic signed [39:0] ip;

  always_comb begin
    sq = 62'(m) * 62'(m);
    mm = sq[61:30];
    fp = 60'(frac) * 60'(lgst_pkg::LN2_Q30) + 60'(lgst_pkg::HALF_Q30);
    pe = $signed({1'b0, p}) - $signed({2'b0, xf});
    ip = 40'(pe) * $signed({10'b0, lgst_pkg::LN2_Q30});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        L_IDLE: begin
          if (start) begin
            xs    <= x;
            p     <= 6'd31;
            xf    <= xfrac;
            state <= L_NORM;
          end
        end
        L_NORM: begin
          if (xs[31] || p == 6'd0) begin
            m     <= xs[31:1];
            frac  <= '0;
            cnt   <= '0;
            state <= L_SQ;
          end else begin
            xs <= {xs[30:0], 1'b0};
            p  <= p - 6'd1;
          end
        end
        L_SQ: begin
          frac <= {frac[28:0], mm[31]};
          m    <= mm[31] ? mm[31:1] : mm[30:0];
          cnt  <= cnt + 5'd1;
          if (cnt == 5'd29) state <= L_FRAC;
        end
        L_FRAC: begin
          fr    <= fp[59:30];
          state <= L_SUM;
        end
        L_SUM: begin
          result <= ip + $signed({10'b0, fr});
          done   <= 1'b1;
          state  <= L_IDLE;
        end
        default: state <= L_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> rtl/log_generalized_stirling_table.sv
// Query: done follows in the cycle after start, or after S_QRESP when the entry comes from the table memory.
// Rebuild: one ln per entry (longer for small arguments) plus, for M>=2, a logadd of
// 12 Taylor terms, k <= 16 e^-1 steps and a second ln.
// One item at a time; busy is high while an item is at work. No stall on results.
// Reset: registers to defaults, table_ready cleared; table memory is left as is.
`default_nettype none
module log_generalized_stirling_table #(
  parameter int MAX_ROWS = lgst_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = lgst_pkg::DEF_MAX_COLS
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               opcode,
  input  wire logic [7:0]         row_n,
  input  wire logic [7:0]         col_t,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [15:0]        cfg_data,
  output logic                    done,
  output logic signed [31:0]      log_value,
  output logic                    minus_infinity,
  output logic                    out_of_range
);
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CW    = $clog2(MAX_COLS);
  localparam int AW    = RW + CW;
  localparam int DEPTH = MAX_COLS << RW;
  localparam int LW    = lgst_pkg::LN_W;
  localparam int TW    = lgst_pkg::TERM_W;
  localparam int FB    = lgst_pkg::FRAC_BITS;
  localparam int DWD   = lgst_pkg::D_W;

  typedef enum logic [3:0] {
    S_IDLE, S_QRESP, S_INIT, S_ROW, S_LNSTART, S_LNWAIT, S_T, S_LA,
    S_CMUL, S_CDIV, S_CCLAMP, S_CEXP, S_CLN, S_WR, S_DIAG, S_NEXT
  } state_t;

  function automatic logic [AW-1:0] cell_addr(input logic [8:0] n, input logic [8:0] m);
    logic [8:0] mm;
    mm = m - 9'd1;
    return {CW'(mm), RW'(n)};
  endfunction

  // configuration
  logic [15:0] discount;
  logic [8:0]  used_rows;
  logic [6:0]  used_cols;

  always_ff @(posedge clk) begin
    if (rst) begin
      discount  <= '0;
      used_rows <= 9'd256;
      used_cols <= 7'd64;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lgst_pkg::REG_DISCOUNT: discount  <= cfg_data;
        lgst_pkg::REG_ROWS:     used_rows <= cfg_data[8:0];
        lgst_pkg::REG_COLS:     used_cols <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  state_t state;
  logic        table_ready;
  logic [8:0]  built_n, lim_n, n;
  logic [6:0]  built_m, lim_m, m;
  logic signed [31:0] up, up_prev, tval, wval, big;
  logic signed [LW-1:0] tf;
  logic [4:0]  kc;
  logic [29:0] r;
  logic [TW-1:0] term;
  logic signed [32:0] sum;
  logic [TW-1:0] y;
  logic [3:0]  tn;

  // table memory, one read or one write a cycle
  logic [31:0]   mem [DEPTH];
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [31:0]   mem_wdata, mem_rdata;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) mem_rdata <= mem[mem_raddr];
  end

  // units
  logic          ln_start, ln_done;
  logic [31:0]   ln_x;
  logic [4:0]    ln_xfrac;
  logic signed [LW-1:0] ln_res;
  logic          div_start, div_done;
  logic [TW-1:0] div_num, div_q;

  lgst_ln u_ln (
    .clk(clk), .rst(rst), .start(ln_start), .x(ln_x), .xfrac(ln_xfrac),
    .done(ln_done), .result(ln_res)
  );

  lgst_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(tn),
    .done(div_done), .quot(div_q)
  );

  // query decode
  logic q_oor, q_ninf, q_zero, q_read;
  always_comb begin
    q_oor = 1'b0; q_ninf = 1'b0; q_zero = 1'b0; q_read = 1'b0;
    if (!table_ready) q_oor = 1'b1;
    else if ({1'b0, row_n} >= built_n) q_ninf = 1'b1;
    else if (col_t > {1'b0, built_m}) q_oor = 1'b1;
    else if (row_n == col_t) q_zero = 1'b1;
    else if (row_n < col_t || col_t == 8'd0) q_ninf = 1'b1;
    else q_read = 1'b1;
  end

  // build bounds
  logic [8:0] nl_c, mc;
  always_comb begin
    nl_c = used_rows;
    if (int'(used_rows) > MAX_ROWS) nl_c = 9'(MAX_ROWS);
    mc = {2'b0, used_cols};
    if (int'(used_cols) > MAX_COLS) mc = 9'(MAX_COLS);
    if (mc > nl_c) mc = nl_c;
  end

  // datapath helpers
  logic [8:0]  nm1;
  logic [6:0]  m_nx;
  logic        m_go;
  logic [22:0] md;
  logic [31:0] arg_c;
  logic signed [31:0] t_sat;
  logic signed [32:0] dxy;
  logic [32:0] dabs;
  logic [DWD-1:0] dclip;
  logic [60:0] tr, ye;
  logic signed [LW-1:0] corr;

  always_comb begin
    nm1   = n - 9'd1;
    m_nx  = m + 7'd1;
    m_go  = (m_nx <= lim_m) && ({2'b0, m_nx} < n);
    md    = m * discount;
    arg_c = {7'b0, nm1, 16'b0} - {9'b0, md};
    t_sat = lgst_pkg::sat32(41'(tf) + 41'(up));
    dxy   = 33'(up_prev) - 33'(tval);
    dabs  = dxy[32] ? 33'(-dxy) : 33'(dxy);
    dclip = (dabs > 33'(lgst_pkg::CLIP_D)) ? lgst_pkg::CLIP_D : dabs[DWD-1:0];
    tr    = 61'(term) * 61'(r);
    ye    = 61'(y) * 61'(lgst_pkg::EM1_Q30) + 61'(lgst_pkg::HALF_Q30);
    corr  = lgst_pkg::q30_to_frac(ln_res);
  end

  // memory control
  always_comb begin
    mem_we = 1'b0; mem_re = 1'b0;
    mem_waddr = cell_addr(n, {2'b0, m});
    mem_raddr = cell_addr({1'b0, row_n}, {1'b0, col_t});
    mem_wdata = wval;
    case (state)
      S_IDLE: mem_re = start && opcode == lgst_pkg::OP_QUERY && q_read;
      S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = cell_addr(9'd1, 9'd1);
        mem_wdata = '0;
      end
      S_ROW: begin
        mem_re    = n < lim_n;
        mem_raddr = cell_addr(nm1, 9'd1);
      end
      S_WR: mem_we = 1'b1;
      S_DIAG: begin
        mem_we    = n <= {2'b0, lim_m};
        mem_waddr = cell_addr(n, n);
        mem_wdata = '0;
      end
      S_NEXT: begin
        // row n-1 is complete before row n starts, so reads never meet a pending write
        mem_re    = m_go;
        mem_raddr = cell_addr(nm1, {2'b0, m_nx});
      end
      default: ;
    endcase
  end

  assign busy = state != S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      table_ready <= 1'b0;
      built_n     <= '0;
      built_m     <= '0;
      done        <= 1'b0;
      ln_start    <= 1'b0;
      div_start   <= 1'b0;
    end else begin
      done      <= 1'b0;
      ln_start  <= 1'b0;
      div_start <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            if (opcode == lgst_pkg::OP_BUILD) begin
              lim_n <= nl_c;
              lim_m <= mc[6:0];
              state <= S_INIT;
            end else if (q_read) begin
              state <= S_QRESP;
            end else begin
              done           <= 1'b1;
              log_value      <= q_ninf ? lgst_pkg::NEG_CODE : 32'sd0;
              minus_infinity <= q_ninf;
              out_of_range   <= q_oor;
            end
          end
        end
        S_QRESP: begin
          done           <= 1'b1;
          log_value      <= mem_rdata;
          minus_infinity <= 1'b0;
          out_of_range   <= 1'b0;
          state          <= S_IDLE;
        end
        S_INIT: begin
          n     <= 9'd2;
          state <= S_ROW;
        end
        S_ROW: begin
          if (n >= lim_n) begin
            table_ready    <= 1'b1;
            built_n        <= lim_n;
            built_m        <= lim_m;
            done           <= 1'b1;
            log_value      <= '0;
            minus_infinity <= 1'b0;
            out_of_range   <= 1'b0;
            state          <= S_IDLE;
          end else begin
            m     <= 7'd1;
            state <= S_LNSTART;
          end
        end
        S_LNSTART: begin
          // up_prev keeps S(n-1,m-1) from the previous column
          up_prev  <= up;
          up       <= mem_rdata;
          ln_x     <= arg_c;
          ln_xfrac <= 5'd16;
          ln_start <= 1'b1;
          state    <= S_LNWAIT;
        end
        S_LNWAIT: begin
          if (ln_done) begin
            tf    <= corr;
            state <= S_T;
          end
        end
        S_T: begin
          if (m == 7'd1) begin
            wval  <= t_sat;
            state <= S_WR;
          end else begin
            tval  <= t_sat;
            state <= S_LA;
          end
        end
        S_LA: begin
          if (up_prev == lgst_pkg::NEG_CODE) begin
            wval  <= tval;
            state <= S_WR;
          end else if (tval == lgst_pkg::NEG_CODE) begin
            wval  <= up_prev;
            state <= S_WR;
          end else begin
            big   <= (up_prev > tval) ? up_prev : tval;
            kc    <= 5'(dclip >> FB);
            r     <= {dclip[FB-1:0], {lgst_pkg::Q_SHIFT{1'b0}}};
            term  <= lgst_pkg::ONE_Q30;
            sum   <= 33'(lgst_pkg::ONE_Q30);
            tn    <= 4'd1;
            state <= S_CMUL;
          end
        end
        S_CMUL: begin
          div_num   <= tr[60:30];
          div_start <= 1'b1;
          state     <= S_CDIV;
        end
        S_CDIV: begin
          if (div_done) begin
            term <= div_q;
            if (tn[0]) sum <= sum - 33'(div_q);
            else       sum <= sum + 33'(div_q);
            if (tn == 4'(lgst_pkg::TAYLOR_TERMS)) begin
              state <= S_CCLAMP;
            end else begin
              tn    <= tn + 4'd1;
              state <= S_CMUL;
            end
          end
        end
        S_CCLAMP: begin
          y     <= sum[32] ? '0 : sum[TW-1:0];
          state <= S_CEXP;
        end
        S_CEXP: begin
          if (kc != 5'd0) begin
            y  <= ye[60:30];
            kc <= kc - 5'd1;
          end else begin
            ln_x     <= 32'(lgst_pkg::ONE_Q30) + 32'(y);
            ln_xfrac <= 5'd30;
            ln_start <= 1'b1;
            state    <= S_CLN;
          end
        end
        S_CLN: begin
          if (ln_done) begin
            wval  <= lgst_pkg::sat32(41'(big) + 41'(corr));
            state <= S_WR;
          end
        end
        S_WR: state <= (m == 7'd1) ? S_DIAG : S_NEXT;
        S_DIAG: state <= S_NEXT;
        S_NEXT: begin
          if (m_go) begin
            m     <= m_nx;
            state <= S_LNSTART;
          end else begin
            n     <= n + 9'd1;
            state <= S_ROW;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_ninf_code: assert property (@(posedge clk) disable iff (rst)
    done && minus_infinity |-> log_value == lgst_pkg::NEG_CODE)
    else $error("minus infinity beat without the ln(0) code");

  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    done |-> !(minus_infinity && out_of_range))
    else $error("both result flags set");

  a_one_port: assert property (@(posedge clk) disable iff (rst)
    !(mem_we && mem_re))
    else $error("table read and write in the same cycle");

  a_unbuilt: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && opcode == lgst_pkg::OP_QUERY && !table_ready)
      |=> (done && out_of_range))
    else $error("query before rebuild not flagged");

endmodule
`default_nettype wire
